// File: hdl/histogram_median_edge_thresholds_macros.svh
// ----------------------------------------------------------------------------
// histogram_median_edge_thresholds_macros.svh
// Assertion macros for the frame median block; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_MEDIAN_EDGE_THRESHOLDS_MACROS_SVH
`define HISTOGRAM_MEDIAN_EDGE_THRESHOLDS_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HMET_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hmet: same-cycle check failed");
// next-cycle implication
`define HMET_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hmet: next-cycle check failed");
`else
`define HMET_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define HMET_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: hdl/hmet_pkg.sv
// ----------------------------------------------------------------------------
// hmet_pkg
// Widths, constants and the shared item type of the frame median block.
// ----------------------------------------------------------------------------
`default_nettype none

package hmet_pkg;

   localparam int PIXEL_BITS = 8;
   localparam int COUNT_BITS = 24;
   localparam int FIELD_BITS = 8;
   localparam int RATIO_BITS = 10;
   localparam int FRAC_BITS = 8;

   localparam int BIN_COUNT = 1 << PIXEL_BITS;
   localparam int SUM_BITS = COUNT_BITS + PIXEL_BITS;
   localparam int FACTOR_BITS = RATIO_BITS + 1;
   localparam int PROD_BITS = PIXEL_BITS + FACTOR_BITS;

   localparam int QUEUE_IDX_BITS = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_IDX_BITS;
   localparam int QUEUE_FILL_BITS = QUEUE_IDX_BITS + 1;

   localparam logic [PIXEL_BITS-1:0] BIN_LAST = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(26);
   localparam logic [FACTOR_BITS-1:0] RATIO_ONE = FACTOR_BITS'(1 << FRAC_BITS);
   localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] bin;
      logic                  last;
   } hmet_item_type;

endpackage

`default_nettype wire

// File: hdl/hmet_req_if.sv
// ----------------------------------------------------------------------------
// hmet_req_if
// Pixel channel: valid/ready with grey level and end-of-frame mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface hmet_req_if import hmet_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] pixel;
   logic                  last;

   modport source (output valid, output pixel, output last, input ready);
   modport sink (input valid, input pixel, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/hmet_rsp_if.sv
// ----------------------------------------------------------------------------
// hmet_rsp_if
// Result channel: valid/ready with median and both edge thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

interface hmet_rsp_if import hmet_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] median;
   logic [FIELD_BITS-1:0] low_threshold;
   logic [FIELD_BITS-1:0] high_threshold;

   modport source (output valid, output median, output low_threshold,
                   output high_threshold, input ready);
   modport sink (input valid, input median, input low_threshold,
                 input high_threshold, output ready);
endinterface

`default_nettype wire

// File: hdl/hmet_front.sv
// ----------------------------------------------------------------------------
// hmet_front
// Accepts pixel beats, maps them to a bin and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hmet_front import hmet_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   hmet_req_if.sink     req_chan,
   output hmet_item_type q_item,
   output logic         q_valid,
   input  wire logic    q_pop
);

   hmet_item_type              queue_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_IDX_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_FILL_BITS-1:0] fill_ff, fill_in;
   logic                       push;
   logic                       pop;
   hmet_item_type              item_in;

   assign req_chan.ready = (fill_ff != QUEUE_FILL_BITS'(QUEUE_DEPTH));
   assign push = req_chan.valid && req_chan.ready;
   assign q_valid = (fill_ff != '0);
   assign pop = q_pop && q_valid;
   assign q_item = queue_ff[rd_ptr_ff];

   always_comb begin
      item_in.bin = PIXEL_BITS'(req_chan.pixel);
      item_in.last = req_chan.last;
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_IDX_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_IDX_BITS'(1) : rd_ptr_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + QUEUE_FILL_BITS'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QUEUE_FILL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/hmet_back.sv
// ----------------------------------------------------------------------------
// hmet_back
// Histogram update, end-of-frame bin scan with clear, threshold arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none
`include "histogram_median_edge_thresholds_macros.svh"

module hmet_back import hmet_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire hmet_item_type         q_item,
   input  wire logic                  q_valid,
   output logic                       q_pop,
   input  wire logic [RATIO_BITS-1:0] edge_ratio,
   hmet_rsp_if.source                 rsp_chan
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_RUN   = 7'b0000010,
      ST_FLUSH = 7'b0000100,
      ST_SCAN  = 7'b0001000,
      ST_TAIL  = 7'b0010000,
      ST_MULT  = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] bin_mem [BIN_COUNT];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  rd_en;
   logic [PIXEL_BITS-1:0] rd_addr;
   logic                  wr_en;
   logic [PIXEL_BITS-1:0] wr_addr;
   logic [COUNT_BITS-1:0] wr_data;

   logic [PIXEL_BITS-1:0] addr_ff, addr_in;
   logic                  upd_vld_ff;
   logic [PIXEL_BITS-1:0] upd_bin_ff;
   logic                  fwd_vld_ff;
   logic [PIXEL_BITS-1:0] fwd_bin_ff;
   logic [COUNT_BITS-1:0] fwd_data_ff;
   logic [COUNT_BITS-1:0] upd_base;
   logic [COUNT_BITS-1:0] upd_next;

   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic                  acc_vld_ff;
   logic [PIXEL_BITS-1:0] acc_idx_ff;
   logic [SUM_BITS-1:0]   run_ff, run_in;
   logic                  found_ff, found_in;
   logic [PIXEL_BITS-1:0] median_ff, median_in;
   logic [PIXEL_BITS-1:0] med_sel;

   logic [FACTOR_BITS-1:0]          lo_factor;
   logic [PROD_BITS-1:0]            lo_prod_ff;
   logic [PROD_BITS-1:0]            hi_prod_ff;
   logic [PROD_BITS-FRAC_BITS-1:0]  hi_shift;

   logic                  rsp_free;
   logic                  rsp_load;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] rsp_median_ff;
   logic [FIELD_BITS-1:0] rsp_low_ff;
   logic [FIELD_BITS-1:0] rsp_high_ff;

   assign q_pop = (state_ff == ST_RUN) && q_valid;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load = (state_ff == ST_EMIT) && rsp_free;
   assign med_sel = found_ff ? median_ff : BIN_LAST;

   // read-modify-write with one level of bypass for back-to-back same bin
   always_comb begin
      upd_base = (fwd_vld_ff && (fwd_bin_ff == upd_bin_ff)) ? fwd_data_ff : rd_data_ff;
      upd_next = (upd_base == COUNT_MAX) ? upd_base : upd_base + COUNT_BITS'(1);
   end

   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff;
      rd_en = 1'b0;
      rd_addr = q_item.bin;
      wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      total_in = total_ff;
      run_in = run_ff;
      found_in = found_ff;
      median_in = median_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      if (upd_vld_ff) begin
         wr_en = 1'b1;
         wr_addr = upd_bin_ff;
         wr_data = upd_next;
      end

      if (acc_vld_ff) begin
         run_in = run_ff + SUM_BITS'(rd_data_ff);
         if (!found_ff && (run_in > SUM_BITS'(total_ff >> 1))) begin
            found_in = 1'b1;
            median_in = acc_idx_ff;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            addr_in = addr_ff + PIXEL_BITS'(1);
            if (addr_ff == BIN_LAST) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (q_pop) begin
               rd_en = 1'b1;
               if (total_ff != COUNT_MAX) begin
                  total_in = total_ff + COUNT_BITS'(1);
               end
               if (q_item.last) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            addr_in = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rd_en = 1'b1;
            rd_addr = addr_ff;
            wr_en = 1'b1;
            addr_in = addr_ff + PIXEL_BITS'(1);
            if (addr_ff == BIN_LAST) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_MULT;
         end
         ST_MULT: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               total_in = '0;
               run_in = '0;
               found_in = 1'b0;
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            addr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= bin_mem[rd_addr];
      end
      if (wr_en) begin
         bin_mem[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      lo_factor = (edge_ratio < RATIO_BITS'(RATIO_ONE))
                  ? RATIO_ONE - FACTOR_BITS'(edge_ratio) : '0;
      hi_shift = hi_prod_ff[PROD_BITS-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      upd_bin_ff <= q_item.bin;
      fwd_bin_ff <= upd_bin_ff;
      fwd_data_ff <= upd_next;
      acc_idx_ff <= addr_ff;
      median_ff <= median_in;
      if (state_ff == ST_MULT) begin
         lo_prod_ff <= PROD_BITS'(med_sel) * PROD_BITS'(lo_factor);
         hi_prod_ff <= PROD_BITS'(med_sel) * PROD_BITS'(RATIO_ONE + FACTOR_BITS'(edge_ratio));
      end
      if (rsp_load) begin
         rsp_median_ff <= med_sel[FIELD_BITS-1:0];
         rsp_low_ff <= lo_prod_ff[FRAC_BITS +: FIELD_BITS];
         rsp_high_ff <= (hi_shift > (PROD_BITS-FRAC_BITS)'(FIELD_MAX))
                        ? FIELD_MAX : hi_shift[FIELD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff <= '0;
         upd_vld_ff <= 1'b0;
         fwd_vld_ff <= 1'b0;
         acc_vld_ff <= 1'b0;
         total_ff <= '0;
         run_ff <= '0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         upd_vld_ff <= q_pop;
         fwd_vld_ff <= upd_vld_ff;
         acc_vld_ff <= (state_ff == ST_SCAN);
         total_ff <= total_in;
         run_ff <= run_in;
         found_ff <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.median = rsp_median_ff;
   assign rsp_chan.low_threshold = rsp_low_ff;
   assign rsp_chan.high_threshold = rsp_high_ff;

   `HMET_ASSERT_NOW(a_upd_only_in_frame, clock, reset, upd_vld_ff, (state_ff == ST_RUN) || (state_ff == ST_FLUSH))
   `HMET_ASSERT_NOW(a_median_found, clock, reset, state_ff == ST_MULT, found_ff)
   `HMET_ASSERT_NEXT(a_emit_loads_rsp, clock, reset, rsp_load, rsp_valid_ff && (state_ff == ST_RUN))

endmodule

`default_nettype wire

// File: hdl/histogram_median_edge_thresholds.sv
// ----------------------------------------------------------------------------
// histogram_median_edge_thresholds
// Frame grey-level median and edge thresholds from a pixel histogram.
//
//   channel    dir   handshake          payload
//   req_chan   in    valid/ready        pixel, last
//   rsp_chan   out   valid/ready        median, low_threshold, high_threshold
//   csr_*      in    csr_we             csr_wdata (edge_ratio)
//
// One beat per cycle within a frame. After the last beat the back end passes
// through a flush state, reads and clears every bin in turn, then takes the sum,
// the products and the result load in states of their own. The four-beat queue
// then fills and stalls the input.
// Reset runs a clearing pass over every bin; only the queue fills meanwhile.
// A stalled result holds in the output register and stalls the next frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_median_edge_thresholds import hmet_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   hmet_req_if.sink                   req_chan,
   hmet_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [RATIO_BITS-1:0] csr_wdata
);

   logic [RATIO_BITS-1:0] ratio_ff, ratio_in;
   hmet_item_type         q_item;
   logic                  q_valid;
   logic                  q_pop;

   assign ratio_in = csr_we ? csr_wdata : ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= RATIO_RESET;
      end else begin
         ratio_ff <= ratio_in;
      end
   end

   hmet_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_item   (q_item),
      .q_valid  (q_valid),
      .q_pop    (q_pop)
   );

   hmet_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_item     (q_item),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .edge_ratio (ratio_ff),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire
